// ===== rtl/slps_pkg.sv =====
package slps_pkg;

    localparam int TimeW   = 32;
    localparam int PeriodW = 24;
    localparam int DutyW   = 5;
    localparam int ColourW = 24;
    localparam int BlinkW  = 8;
    localparam int CycleW  = 6;
    localparam int ThrW    = PeriodW + 1;

    localparam logic [2:0] MODE_BLINK  = 3'd2;
    localparam logic [2:0] MODE_ORANGE = 3'd3;
    localparam logic [2:0] MODE_NORMAL = 3'd4;
    localparam logic [2:0] MODE_WHITE  = 3'd5;

    localparam logic [2:0] PROTO_ONE  = 3'd1;
    localparam logic [2:0] PROTO_LAST = 3'd5;

    localparam logic [ColourW-1:0] COL_RED    = 24'h00_ff_00;
    localparam logic [ColourW-1:0] COL_GREEN  = 24'ha0_00_00;
    localparam logic [ColourW-1:0] COL_ORANGE = 24'ha5_ff_00;
    localparam logic [ColourW-1:0] COL_BLUE   = 24'h7f_00_ff;
    localparam logic [ColourW-1:0] COL_WHITE  = 24'hff_ff_ff;
    localparam logic [ColourW-1:0] COL_BLACK  = 24'h00_00_00;

    localparam logic [PeriodW-1:0] PERIOD_RESET = 24'd500000;
    localparam logic [DutyW-1:0]   DUTY_RESET   = 5'd8;

    localparam logic [0:0] REG_PERIOD = 1'd0;
    localparam logic [0:0] REG_DUTY   = 1'd1;

    // Per-frame decision, before the flash phase is known.
    typedef struct packed {
        logic               emit;
        logic               flash;
        logic [ColourW-1:0] colour;
    } pat_res_t;

    // Frame count at which each blink pattern restarts.
    function automatic logic [BlinkW-1:0] blink_end(input logic [2:0] proto);
        logic [BlinkW-1:0] e;
        case (proto)
            3'd0:    e = 8'd80;
            3'd1:    e = 8'd100;
            3'd2:    e = 8'd140;
            3'd3:    e = 8'd170;
            3'd4:    e = 8'd200;
            default: e = 8'd230;
        endcase
        return e;
    endfunction

    // 30*(p+1)-10: end of the last green window.
    function automatic logic [BlinkW-1:0] blink_lit_end(input logic [2:0] proto);
        logic [BlinkW-1:0] e;
        case (proto)
            3'd0:    e = 8'd20;
            3'd1:    e = 8'd50;
            3'd2:    e = 8'd80;
            3'd3:    e = 8'd110;
            3'd4:    e = 8'd140;
            default: e = 8'd170;
        endcase
        return e;
    endfunction

    // True where count mod 30 falls in the dark part [20,30) of a period.
    function automatic logic blink_dark(input logic [BlinkW-1:0] c);
        logic d;
        d = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (c >= BlinkW'(30 * k + 20) && c < BlinkW'(30 * k + 30)) begin
                d = 1'b1;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/status_led_pattern_sequencer.sv =====
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    status flags, mode, protocol, time_us
// m_axis    out  m_axis_tvalid / m_axis_tready    colour_grb
// cfg       in   cfg_we (no wait)                 flash_period_us, flash_duty_sixteenths
//
// A flashing item runs the bit-serial remainder unit (one dividend bit per cycle)
// over time_us, then decides the colour and loads the output register;
// s_axis_tready returns once the sequencer is idle again, so no new item is
// taken before the last one is through. Steady, blink and cycle items go from
// the transfer straight to the output register; items with no result stay idle.
// aresetn is synchronous, active low; it clears the frame counters, the
// sequencer, the output valid and loads the register reset values.
// s_axis_tready is high only while the sequencer is idle; a result waiting
// on m_axis holds the sequencer in its final state until it is taken.
module status_led_pattern_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] low_voltage, [1] link_lost, [4:2] led_mode, [7:5] receiver_protocol,
    // [8] cycle_colours, [40:9] time_us, [47:41] zero
    input  logic [47:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [23:0] colour_grb
    output logic [slps_pkg::ColourW-1:0]      m_axis_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [slps_pkg::PeriodW-1:0]      cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [slps_pkg::PeriodW-1:0] period_reg;
    logic [slps_pkg::DutyW-1:0]   duty_reg;
    logic [slps_pkg::ThrW-1:0]    thr_reg;
    logic [slps_pkg::ColourW-1:0] colour_reg, colour_next;
    logic                         m_valid_reg, m_valid_next;
    logic [slps_pkg::ColourW-1:0] m_data_reg, m_data_next;

    logic                         s_xfer;
    logic                         mod_start;
    logic                         mod_done;
    logic [slps_pkg::PeriodW-1:0] mod_rem;
    logic [slps_pkg::PeriodW+slps_pkg::DutyW-1:0] thr_prod;
    logic                         first_phase;
    slps_pkg::pat_res_t           pat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign mod_start     = s_xfer && pat.emit && pat.flash;

    // Frame counters and colour selection; counters advance on the input transfer.
    slps_pattern u_pattern (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .commit            (s_xfer),
        .low_voltage       (s_axis_tdata[0]),
        .link_lost         (s_axis_tdata[1]),
        .led_mode          (s_axis_tdata[4:2]),
        .receiver_protocol (s_axis_tdata[7:5]),
        .cycle_colours     (s_axis_tdata[8]),
        .res               (pat)
    );

    // time_us mod period, one bit per cycle.
    slps_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_axis_tdata[40:9]),
        .divisor   (period_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // thr_reg=(period*duty)>>4 at transfer; user holds config static then, unenforced.
    assign thr_prod = period_reg * duty_reg;

    // Show the first colour past the threshold; a zero period always reads black.
    assign first_phase = (period_reg != '0) && ({1'b0, mod_rem} > thr_reg);

    always_comb begin
        state_next   = state_reg;
        colour_next  = colour_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_axis_tvalid && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    colour_next = pat.colour;
                    if (!pat.emit) begin
                        state_next = ST_IDLE;
                    end else if (pat.flash) begin
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    colour_next = first_phase ? colour_reg : slps_pkg::COL_BLACK;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free, then load it.
                if (!m_valid_next) begin
                    m_valid_next = 1'b1;
                    m_data_next  = colour_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        colour_reg <= colour_next;
        m_data_reg <= m_data_next;
        if (s_xfer) begin
            thr_reg <= thr_prod[slps_pkg::PeriodW+slps_pkg::DutyW-1:4];
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            period_reg  <= slps_pkg::PERIOD_RESET;
            duty_reg    <= slps_pkg::DUTY_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    slps_pkg::REG_PERIOD: period_reg <= cfg_wdata;
                    slps_pkg::REG_DUTY:   duty_reg   <= cfg_wdata[slps_pkg::DutyW-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== rtl/slps_mod_unit.sv =====
module slps_mod_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [slps_pkg::TimeW-1:0]       dividend,
    input  logic [slps_pkg::PeriodW-1:0]     divisor,
    output logic                             done,
    output logic [slps_pkg::PeriodW-1:0]     remainder
);

    logic [slps_pkg::TimeW-1:0]   quo_reg, quo_next;
    logic [slps_pkg::PeriodW-1:0] rem_reg, rem_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [slps_pkg::PeriodW:0]   trial;
    logic [slps_pkg::PeriodW:0]   diff;

    // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
    assign trial = {rem_reg, quo_reg[slps_pkg::TimeW-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[slps_pkg::TimeW-2:0], 1'b0};
            rem_next = diff[slps_pkg::PeriodW] ? trial[slps_pkg::PeriodW-1:0]
                                               : diff[slps_pkg::PeriodW-1:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(slps_pkg::TimeW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/slps_pattern.sv =====
module slps_pattern (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                commit,
    input  logic                low_voltage,
    input  logic                link_lost,
    input  logic [2:0]          led_mode,
    input  logic [2:0]          receiver_protocol,
    input  logic                cycle_colours,
    output slps_pkg::pat_res_t  res
);

    logic [slps_pkg::BlinkW-1:0] blink_reg, blink_next;
    logic [slps_pkg::CycleW-1:0] cycle_reg, cycle_next;
    logic [slps_pkg::CycleW-1:0] cyc_inc;
    logic                        green;

    assign cyc_inc = cycle_reg + 6'd1;

    always_comb begin
        if (receiver_protocol == slps_pkg::PROTO_ONE) begin
            green = (blink_reg < 8'd20) || (blink_reg >= 8'd30 && blink_reg < 8'd40);
        end else begin
            green = (blink_reg < slps_pkg::blink_lit_end(receiver_protocol))
                    && !slps_pkg::blink_dark(blink_reg);
        end
    end

    always_comb begin
        res        = '{emit: 1'b0, flash: 1'b0, colour: slps_pkg::COL_BLACK};
        blink_next = blink_reg;
        cycle_next = cycle_reg;
        if (low_voltage) begin
            res = '{emit: 1'b1, flash: 1'b1, colour: slps_pkg::COL_RED};
        end else if (link_lost) begin
            if (led_mode == slps_pkg::MODE_BLINK) begin
                if (receiver_protocol <= slps_pkg::PROTO_LAST) begin
                    if (blink_reg >= slps_pkg::blink_end(receiver_protocol)) begin
                        blink_next = '0;
                    end else begin
                        blink_next = blink_reg + 8'd1;
                        res.emit   = 1'b1;
                        res.colour = green ? slps_pkg::COL_GREEN : slps_pkg::COL_BLACK;
                    end
                end
            end else if (led_mode == slps_pkg::MODE_ORANGE) begin
                res = '{emit: 1'b1, flash: 1'b1, colour: slps_pkg::COL_ORANGE};
            end
        end else begin
            if (led_mode == slps_pkg::MODE_NORMAL) begin
                if (cycle_colours) begin
                    cycle_next = cyc_inc;
                    res.emit   = 1'b1;
                    if (cyc_inc < 6'd10) begin
                        res.colour = slps_pkg::COL_RED;
                    end else if (cyc_inc < 6'd20) begin
                        res.colour = slps_pkg::COL_GREEN;
                    end else if (cyc_inc < 6'd30) begin
                        res.colour = slps_pkg::COL_ORANGE;
                    end else if (cyc_inc < 6'd40) begin
                        res.colour = slps_pkg::COL_BLUE;
                    end else begin
                        res.emit = 1'b0;
                        if (cyc_inc < 6'd50) begin
                            cycle_next = '0;
                        end
                    end
                end else begin
                    res = '{emit: 1'b1, flash: 1'b0, colour: slps_pkg::COL_BLUE};
                end
            end else if (led_mode == slps_pkg::MODE_WHITE) begin
                res = '{emit: 1'b1, flash: 1'b1, colour: slps_pkg::COL_WHITE};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_reg <= '0;
            cycle_reg <= '0;
        end else if (commit) begin
            blink_reg <= blink_next;
            cycle_reg <= cycle_next;
        end
    end

endmodule

// ===== sim/tb_status_led_pattern_sequencer.sv =====
`timescale 1ns / 100ps

module tb_status_led_pattern_sequencer;

    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES    = 40;    // outlasts a flashing item's path through the remainder unit
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

    // Colours as the LED expects them: green, red, blue from the top byte down.
    localparam logic [23:0] GRB_RED    = {8'd0,   8'd255, 8'd0};
    localparam logic [23:0] GRB_GREEN  = {8'd160, 8'd0,   8'd0};
    localparam logic [23:0] GRB_ORANGE = {8'd165, 8'd255, 8'd0};
    localparam logic [23:0] GRB_BLUE   = {8'd127, 8'd0,   8'd255};
    localparam logic [23:0] GRB_WHITE  = {8'd255, 8'd255, 8'd255};
    localparam logic [23:0] GRB_BLACK  = 24'd0;

    // One frame as it travels on s_axis_tdata, lowest field last.
    typedef struct packed {
        logic [6:0]  spare;
        logic [31:0] time_us;
        logic        cycle_colours;
        logic [2:0]  receiver_protocol;
        logic [2:0]  led_mode;
        logic        link_lost;
        logic        low_voltage;
    } frame_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] low_voltage, [1] link_lost, [4:2] led_mode, [7:5] receiver_protocol,
    // [8] cycle_colours, [40:9] time_us, [47:41] zero
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [23:0] colour_grb
    logic [slps_pkg::ColourW-1:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [slps_pkg::PeriodW-1:0] cfg_wdata = '0;

    // Shadow of the block: registers and frame counters.
    logic [23:0] flash_period = 24'd500000;
    logic [4:0]  flash_duty   = 5'd8;
    logic [7:0]  blink_frames = 8'd0;
    logic [5:0]  cycle_frames = 6'd0;

    logic [23:0] colours_due [$];
    int          faults = 0;
    bit          steady_flow = 1'b0;   // both sides stream with no idle cycles
    bit          hold_request = 1'b0;  // ask the result sink for a long hold-off

    status_led_pattern_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // Frame counts at which each blink pattern wraps back to its start.
    function automatic int blink_length(input int proto);
        case (proto)
            0:       return 80;
            1:       return 100;
            2:       return 140;
            3:       return 170;
            4:       return 200;
            default: return 230;
        endcase
    endfunction

    // Pick the flash colour or black from the current phase within the period.
    function automatic logic [23:0] flash_colour(input logic [23:0] first,
                                                 input logic [31:0] now);
        logic [31:0] phase;
        logic [28:0] prod;
        phase = (flash_period == 24'd0) ? 32'd0 : now % {8'd0, flash_period};
        prod  = 29'(flash_period) * 29'(flash_duty);
        return (phase > {7'd0, prod[28:4]}) ? first : GRB_BLACK;
    endfunction

    // Advance the shadow state by one accepted frame; queue the colour it shows.
    task automatic predict_frame(input frame_t f);
        logic [23:0] col;
        logic [5:0]  n;
        bit          emit;
        bit          lit;
        int          c;
        int          p;
        emit = 1'b0;
        col  = GRB_BLACK;
        c    = blink_frames;
        p    = f.receiver_protocol;
        if (f.low_voltage) begin
            col  = flash_colour(GRB_RED, f.time_us);
            emit = 1'b1;
        end else if (f.link_lost) begin
            if (f.led_mode == slps_pkg::MODE_BLINK) begin
                // Unknown protocols leave the blink counter alone.
                if (f.receiver_protocol <= slps_pkg::PROTO_LAST) begin
                    if (c >= blink_length(p)) begin
                        blink_frames = 8'd0;
                    end else begin
                        if (f.receiver_protocol == slps_pkg::PROTO_ONE) begin
                            // Second blink of the two-blink pattern is only 10 frames long.
                            lit = (c < 20) || (c >= 30 && c < 40);
                        end else begin
                            lit = (c < 30 * (p + 1) - 10) && (c % 30 < 20);
                        end
                        blink_frames = blink_frames + 8'd1;
                        col  = lit ? GRB_GREEN : GRB_BLACK;
                        emit = 1'b1;
                    end
                end
            end else if (f.led_mode == slps_pkg::MODE_ORANGE) begin
                col  = flash_colour(GRB_ORANGE, f.time_us);
                emit = 1'b1;
            end
        end else begin
            if (f.led_mode == slps_pkg::MODE_NORMAL) begin
                if (f.cycle_colours) begin
                    // Bump first, then pick the colour from the new count.
                    n = cycle_frames + 6'd1;
                    cycle_frames = n;
                    emit = (n < 6'd40);
                    if (n < 6'd10) col = GRB_RED;
                    else if (n < 6'd20) col = GRB_GREEN;
                    else if (n < 6'd30) col = GRB_ORANGE;
                    else if (n < 6'd40) col = GRB_BLUE;
                    else if (n < 6'd50) cycle_frames = 6'd0;
                end else begin
                    // Steady blue leaves the cycle counter untouched.
                    col  = GRB_BLUE;
                    emit = 1'b1;
                end
            end else if (f.led_mode == slps_pkg::MODE_WHITE) begin
                col  = flash_colour(GRB_WHITE, f.time_us);
                emit = 1'b1;
            end
        end
        if (emit) colours_due.push_back(col);
    endtask

    function automatic frame_t make_frame(input bit low, input bit lost,
                                          input logic [2:0] mode, input logic [2:0] proto,
                                          input bit cyc, input logic [31:0] now);
        frame_t f;
        f.spare             = '0;
        f.time_us           = now;
        f.cycle_colours     = cyc;
        f.receiver_protocol = proto;
        f.led_mode          = mode;
        f.link_lost         = lost;
        f.low_voltage       = low;
        return f;
    endfunction

    // Any frame, except that blink frames carry an unknown protocol so they
    // do not disturb a running blink pattern.
    function automatic frame_t random_frame();
        frame_t f;
        f = make_frame($urandom_range(0, 9) == 0, $urandom_range(0, 1),
                       3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       $urandom_range(0, 1), $urandom);
        if (!f.low_voltage && f.link_lost && f.led_mode == slps_pkg::MODE_BLINK) begin
            f.receiver_protocol = 3'($urandom_range(6, 7));
        end
        return f;
    endfunction

    // A frame that lands in one of the three flashing branches.
    function automatic frame_t flash_frame(input logic [31:0] now);
        case ($urandom_range(0, 2))
            0: return make_frame(1'b1, $urandom_range(0, 1), 3'($urandom_range(0, 7)),
                                 3'($urandom_range(0, 7)), $urandom_range(0, 1), now);
            1: return make_frame(1'b0, 1'b1, slps_pkg::MODE_ORANGE,
                                 3'($urandom_range(0, 7)), $urandom_range(0, 1), now);
            default: return make_frame(1'b0, 1'b0, slps_pkg::MODE_WHITE,
                                       3'($urandom_range(0, 7)), $urandom_range(0, 1), now);
        endcase
    endfunction

    // Offer one frame, hold it until the transfer, then maybe idle a while.
    task automatic send_frame(input frame_t f);
        int gap;
        s_axis_tdata  <= f;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predict_frame(f);
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, drain every pending colour, then let silent frames finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (colours_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == slps_pkg::REG_PERIOD) flash_period = value;
        else flash_duty = value[4:0];
        @(posedge aclk);
    endtask

    task automatic set_flash(input logic [23:0] period, input logic [4:0] duty);
        settle();
        write_reg(slps_pkg::REG_PERIOD, period);
        write_reg(slps_pkg::REG_DUTY, {19'd0, duty});
    endtask

    // Reset settings, priority order, every mode in both branches, and the
    // frames that must produce nothing.
    task automatic test_priority_directed();
        // Low voltage wins over everything; flash edges at the reset period.
        send_frame(make_frame(1'b1, 1'b1, slps_pkg::MODE_BLINK, 3'd0, 1'b0, 32'd0));
        send_frame(make_frame(1'b1, 1'b0, slps_pkg::MODE_WHITE, 3'd7, 1'b1, 32'hffff_ffff));
        send_frame(make_frame(1'b1, 1'b0, 3'd0, 3'd0, 1'b0, 32'd250000));
        send_frame(make_frame(1'b1, 1'b1, 3'd7, 3'd0, 1'b0, 32'd250001));
        // Failsafe orange flash, both phases.
        send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_ORANGE, 3'd0, 1'b0, 32'd499999));
        send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_ORANGE, 3'd0, 1'b0, 32'd100));
        // Modes without meaning in failsafe.
        for (int m = 0; m < 8; m++) begin
            if (3'(m) != slps_pkg::MODE_BLINK && 3'(m) != slps_pkg::MODE_ORANGE) begin
                send_frame(make_frame(1'b0, 1'b1, 3'(m), 3'd0, 1'b1, $urandom));
            end
        end
        // Unknown protocols are ignored, then the first blink frame.
        send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_BLINK,
                              slps_pkg::PROTO_LAST + 3'd1, 1'b0, 32'd0));
        send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_BLINK,
                              slps_pkg::PROTO_LAST + 3'd2, 1'b1, 32'd0));
        send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_BLINK, 3'd0, 1'b0, 32'd0));
        // Normal branch: steady blue, first cycle step, white flash.
        send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_NORMAL, 3'd0, 1'b0, 32'd0));
        send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_NORMAL, 3'd0, 1'b1, 32'd0));
        send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_WHITE, 3'd0, 1'b0, 32'd400000));
        send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_WHITE, 3'd0, 1'b0, 32'd0));
        // Modes without meaning in normal operation.
        for (int m = 0; m < 8; m++) begin
            if (3'(m) != slps_pkg::MODE_NORMAL && 3'(m) != slps_pkg::MODE_WHITE) begin
                send_frame(make_frame(1'b0, 1'b0, 3'(m), 3'd7, 1'b1, $urandom));
            end
        end
    endtask

    // Walk the flash settings through their extremes, zero period and duty
    // above sixteen included; aim half the times right at the threshold.
    task automatic test_flash_thresholds();
        logic [23:0] per;
        logic [4:0]  duty;
        logic [31:0] cut;
        logic [31:0] now;
        for (int s = 0; s < 8; s++) begin
            case (s)
                0:       begin per = 24'd16;       duty = 5'd8;  end
                1:       begin per = 24'd1;        duty = 5'd0;  end
                2:       begin per = 24'hff_ffff;  duty = 5'd16; end
                3:       begin per = 24'd0;        duty = 5'd5;  end
                4:       begin per = 24'd100;      duty = 5'd31; end
                5:       begin per = 24'hff_ffff;  duty = 5'd0;  end
                6:       begin per = 24'd7;        duty = 5'd17; end
                default: begin per = 24'd500000;   duty = 5'd8;  end
            endcase
            set_flash(per, duty);
            cut = (32'(per) * 32'(duty)) >> 4;
            for (int i = 0; i < 20; i++) begin
                if (i % 2 == 0) now = $urandom;
                else now = 32'($urandom_range(0, 50)) * 32'(per) + cut
                           + 32'($urandom_range(0, 2)) - 32'd1;
                send_frame(flash_frame(now));
            end
        end
    endtask

    // Run the colour cycle past its wrap, with stray frames mixed in;
    // steady blue frames in between must not move it.
    task automatic test_colour_cycle();
        int r;
        for (int i = 0; i < 100; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_NORMAL,
                                      3'($urandom_range(0, 7)), 1'b1, $urandom));
            end else if (r < 85) begin
                send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_NORMAL,
                                      3'($urandom_range(0, 7)), 1'b0, $urandom));
            end else begin
                send_frame(random_frame());
            end
        end
    endtask

    // Hold the result side off while frames keep coming, so the block
    // backs up and drops s_axis_tready.
    task automatic test_output_backpressure();
        settle();
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if ($urandom_range(0, 1) == 1) send_frame(flash_frame($urandom));
            else send_frame(make_frame(1'b0, 1'b0, slps_pkg::MODE_NORMAL,
                                       3'd0, 1'b0, $urandom));
        end
    endtask

    // One blink run per protocol, each a little past its wrap, under a new
    // flash setting, with random frames and the odd wrong protocol mixed in.
    task automatic test_random_traffic();
        logic [23:0] per;
        logic [4:0]  duty;
        int          first;
        int          p;
        int          frames;
        int          sel;
        int          r;
        first = $urandom_range(0, 5);
        for (int k = 0; k < 6; k++) begin
            p   = (first + k) % 6;
            sel = $urandom_range(0, 9);
            if (sel < 6) per = 24'($urandom_range(1, 100));
            else if (sel < 8) per = 24'($urandom_range(1, 24'hff_ffff));
            else if (sel == 8) per = 24'hff_ffff;
            else per = 24'($urandom_range(0, 1));
            duty = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                                : 5'($urandom_range(0, 16));
            set_flash(per, duty);
            steady_flow = (k % 2 == 1);
            frames = blink_length(p) + 1 + $urandom_range(0, 5);
            while (frames > 0) begin
                r = $urandom_range(0, 199);
                if (r < 40) begin
                    send_frame(random_frame());
                end else if (r == 40) begin
                    send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_BLINK,
                                          3'($urandom_range(0, 7)), $urandom_range(0, 1),
                                          $urandom));
                end else begin
                    send_frame(make_frame(1'b0, 1'b1, slps_pkg::MODE_BLINK, 3'(p),
                                          $urandom_range(0, 1), $urandom));
                    frames--;
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    // Result sink: random stalls, or one long counted hold-off on request.
    initial begin : result_sink
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    // Compare every colour transfer with the oldest pending prediction.
    always @(posedge aclk) begin : colour_check
        logic [23:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (colours_due.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("colour_grb: none expected, got %06h", m_axis_tdata);
                end
            end else begin
                want = colours_due.pop_front();
                if (m_axis_tdata !== want) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("colour_grb: expected %06h, got %06h", want, m_axis_tdata);
                    end
                end
            end
        end
    end

    // Abort when neither side has moved a transfer for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_status_led_pattern_sequencer: FAIL");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_priority_directed();
        test_flash_thresholds();
        test_colour_cycle();
        test_output_backpressure();
        test_random_traffic();
        settle();
        faults += colours_due.size();
        if (faults == 0) begin
            $display("tb_status_led_pattern_sequencer: PASS");
        end else begin
            $display("tb_status_led_pattern_sequencer: FAIL");
        end
        $finish;
    end

endmodule
